[rtl/core/adsr_pkg.sv]
// Shared types and constants of the ADSR envelope and VCA core.
package adsr_pkg;

  localparam int unsigned TickW  = 24;
  localparam int unsigned LevelW = 17;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned SampW  = 16;
  localparam int unsigned QuotW  = 17;
  localparam int unsigned NumW   = QuotW + TickW;
  localparam int unsigned MulAW  = LevelW + 1;
  localparam int unsigned MulBW  = TickW + 1;
  localparam int unsigned ProdW  = MulAW + MulBW;
  localparam int unsigned CntW   = 5;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 24;
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  localparam logic [LevelW-1:0] LevelOne = 17'h10000;

  localparam logic [TickW-1:0]  AttackRst  = 24'd4800;
  localparam logic [TickW-1:0]  DecayRst   = 24'd4800;
  localparam logic [LevelW-1:0] SustainRst = 17'd45875;
  localparam logic [TickW-1:0]  ReleaseRst = 24'd14400;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ATTACK  = 2'd0,
    CFG_DECAY   = 2'd1,
    CFG_SUSTAIN = 2'd2,
    CFG_RELEASE = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_e;

endpackage

[rtl/core/adsr_envelope_vca_core.sv]
// Linear ADSR envelope generator with a VCA multiply, built on a shared divider and multiplier.
//
// Usage: one item per audio sample enters on the s_axis channel; it carries the gate level,
// the time stamp in ticks and the signed sample (tdata), plus the invalid-sample flag (tuser).
// One result leaves on the m_axis channel for every item: the scaled sample and the envelope
// level after this step. The user writes envelope times and the sustain level on the cfg port
// only while idle, not enforced by the block; index 0 attack, 1 decay, 2 sustain, 3 release.
// Sequence: a decay or release step passes through phase bookkeeping, one multiply for the
// numerator, the 17 steps of the restoring divider (one quotient bit per cycle), one VCA
// multiply, a rounding step and the load of the output register, on which m_axis_tvalid
// rises. An attack step skips the numerator multiply, a step that needs no division skips
// the multiply and the divider, and an invalid sample goes straight to the output register.
// Flow: one item at a time; s_axis_tready is high only while the sequencer is idle, so a new
// item is taken only after the last result has been passed to the output register.
// The 17-step divider is the longest part of the sequence.
// The output register holds a finished result; the next item is taken while it waits.
// If the receiver stalls, the sequencer holds the following result until the register is
// free. Reset clears the envelope state and loads the default register values.
module adsr_envelope_vca_core
  import adsr_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // gate [0], time_tick [32:1], sample_in [48:33], zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // sample_invalid [0]
  input  logic                s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // sample_out [15:0], level [32:16], zero pad
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PREP = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_VCA  = 3'd4;
  localparam logic [2:0] ST_RND  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  localparam logic [CntW-1:0] DivLast = CntW'(QuotW - 1);

  // Control state
  logic [2:0]        state_q, state_d;
  phase_e            phase_q, phase_d;
  logic [LevelW-1:0] env_q, env_d;
  logic [LevelW-1:0] cap_q, cap_d;
  logic              gate_seen_q, gate_seen_d;
  logic [TimeW-1:0]  start_q, start_d;
  logic [TimeW-1:0]  stop_q, stop_d;
  logic [TickW-1:0]  attack_q, decay_q, release_q;
  logic [LevelW-1:0] sustain_q;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              mvalid_q, mvalid_d;

  // Payload
  logic              gate_q, gate_d;
  logic [TimeW-1:0]  time_q, time_d;
  logic [SampW-1:0]  samp_q, samp_d;
  logic [LevelW-1:0] opa_q, opa_d;
  logic [TickW-1:0]  opb_q, opb_d;
  logic [TickW-1:0]  den_q, den_d;
  logic              sub_q, sub_d;
  logic [TickW-1:0]  rem_q, rem_d;
  logic [QuotW-1:0]  nlo_q, nlo_d;
  logic [QuotW-1:0]  quot_q, quot_d;
  logic [ProdW-1:0]  prod_q, prod_d;
  logic [SampW-1:0]  res_samp_q, res_samp_d;
  logic [LevelW-1:0] res_lvl_q, res_lvl_d;
  logic [SampW-1:0]  out_samp_q, out_samp_d;
  logic [LevelW-1:0] out_lvl_q, out_lvl_d;

  logic              in_xfer, out_free;
  logic [LevelW-1:0] sus_sat;
  logic              rise, fall;
  phase_e            ph_eff;
  logic [TimeW-1:0]  start_eff, stop_eff;
  logic [LevelW-1:0] cap_eff;
  logic [TimeW-1:0]  d_att, d_rel, e_dec;
  logic              att_run, dec_run, rel_run;
  logic [NumW-1:0]   att_num;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [ProdW-1:0] mul_p;
  logic [TickW:0]    rem2, diff;
  logic              ge;
  logic [QuotW-1:0]  q_fin;
  logic [ProdW-1:0]  rounded;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !mvalid_q || m_axis_tready;
  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {{(OutDataW - SampW - LevelW){1'b0}}, out_lvl_q, out_samp_q};

  assign sus_sat = (sustain_q > LevelOne) ? LevelOne : sustain_q;

  // Gate edges and the time checks of each phase.
  assign rise      = gate_q && !gate_seen_q;
  assign fall      = !gate_q && gate_seen_q;
  assign ph_eff    = rise ? PH_ATTACK : (fall ? PH_RELEASE : phase_q);
  assign start_eff = rise ? time_q : start_q;
  assign stop_eff  = fall ? time_q : stop_q;
  assign cap_eff   = fall ? env_q : cap_q;
  assign d_att     = time_q - start_eff;
  assign d_rel     = time_q - stop_eff;
  assign att_run   = d_att < {{(TimeW - TickW){1'b0}}, attack_q};
  assign e_dec     = att_run ? '0 : d_att - {{(TimeW - TickW){1'b0}}, attack_q};
  assign dec_run   = e_dec < {{(TimeW - TickW){1'b0}}, decay_q};
  assign rel_run   = d_rel < {{(TimeW - TickW){1'b0}}, release_q};
  assign att_num   = {1'b0, d_att[TickW-1:0], 16'b0};

  // The one multiplier: numerator products, then the sample scaling.
  always_comb begin
    if (state_q == ST_MUL) begin
      mul_a = $signed({1'b0, opa_q});
      mul_b = $signed({1'b0, opb_q});
    end else begin
      mul_a = $signed({1'b0, env_q});
      mul_b = $signed({{(MulBW - SampW){samp_q[SampW-1]}}, samp_q});
    end
  end
  assign mul_p = mul_a * mul_b;

  // Restoring divider step, one quotient bit per cycle.
  assign rem2  = {rem_q, nlo_q[QuotW-1]};
  assign diff  = rem2 - {1'b0, den_q};
  assign ge    = rem2 >= {1'b0, den_q};
  assign q_fin = {quot_q[QuotW-2:0], ge};

  assign rounded = prod_q + ProdW'(32768);

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    env_d       = env_q;
    cap_d       = cap_q;
    gate_seen_d = gate_seen_q;
    start_d     = start_q;
    stop_d      = stop_q;
    cnt_d       = cnt_q;
    mvalid_d    = mvalid_q && !m_axis_tready;
    gate_d      = gate_q;
    time_d      = time_q;
    samp_d      = samp_q;
    opa_d       = opa_q;
    opb_d       = opb_q;
    den_d       = den_q;
    sub_d       = sub_q;
    rem_d       = rem_q;
    nlo_d       = nlo_q;
    quot_d      = quot_q;
    prod_d      = prod_q;
    res_samp_d  = res_samp_q;
    res_lvl_d   = res_lvl_q;
    out_samp_d  = out_samp_q;
    out_lvl_d   = out_lvl_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          gate_d = s_axis_tdata[0];
          time_d = s_axis_tdata[TimeW:1];
          samp_d = s_axis_tdata[TimeW+SampW:TimeW+1];
          if (s_axis_tuser) begin
            res_samp_d = '0;
            res_lvl_d  = env_q;
            state_d    = ST_FIN;
          end else begin
            state_d = ST_PREP;
          end
        end
      end
      ST_PREP: begin
        gate_seen_d = gate_q;
        start_d     = start_eff;
        stop_d      = stop_eff;
        cap_d       = cap_eff;
        state_d     = ST_VCA;
        case (ph_eff)
          PH_ATTACK: begin
            if (att_run) begin
              phase_d = PH_ATTACK;
              rem_d   = att_num[NumW-1:QuotW];
              nlo_d   = att_num[QuotW-1:0];
              den_d   = attack_q;
              sub_d   = 1'b0;
              cnt_d   = '0;
              state_d = ST_DIV;
            end else begin
              // Attack just ended: the level is held for this sample.
              phase_d = PH_DECAY;
            end
          end
          PH_DECAY: begin
            if (dec_run) begin
              phase_d = PH_DECAY;
              opa_d   = LevelOne - sus_sat;
              opb_d   = e_dec[TickW-1:0];
              den_d   = decay_q;
              sub_d   = 1'b1;
              state_d = ST_MUL;
            end else begin
              phase_d = PH_SUSTAIN;
              env_d   = sus_sat;
            end
          end
          PH_SUSTAIN: begin
            phase_d = PH_SUSTAIN;
            env_d   = sus_sat;
          end
          PH_RELEASE: begin
            if (rel_run) begin
              phase_d = PH_RELEASE;
              opa_d   = cap_eff;
              opb_d   = release_q - d_rel[TickW-1:0];
              den_d   = release_q;
              sub_d   = 1'b0;
              state_d = ST_MUL;
            end else begin
              phase_d = PH_IDLE;
              env_d   = '0;
            end
          end
          default: begin
            phase_d = PH_IDLE;
            env_d   = '0;
          end
        endcase
      end
      ST_MUL: begin
        rem_d   = mul_p[NumW-1:QuotW];
        nlo_d   = mul_p[QuotW-1:0];
        cnt_d   = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = ge ? diff[TickW-1:0] : rem2[TickW-1:0];
        nlo_d  = {nlo_q[QuotW-2:0], 1'b0};
        quot_d = q_fin;
        cnt_d  = cnt_q + CntW'(1);
        if (cnt_q == DivLast) begin
          env_d   = sub_q ? LevelOne - q_fin : q_fin;
          state_d = ST_VCA;
        end
      end
      ST_VCA: begin
        prod_d  = mul_p;
        state_d = ST_RND;
      end
      ST_RND: begin
        res_samp_d = rounded[31:16];
        res_lvl_d  = env_q;
        state_d    = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_samp_d = res_samp_q;
          out_lvl_d  = res_lvl_q;
          mvalid_d   = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= PH_IDLE;
      env_q       <= '0;
      cap_q       <= '0;
      gate_seen_q <= 1'b0;
      start_q     <= '0;
      stop_q      <= '0;
      cnt_q       <= '0;
      mvalid_q    <= 1'b0;
      attack_q    <= AttackRst;
      decay_q     <= DecayRst;
      sustain_q   <= SustainRst;
      release_q   <= ReleaseRst;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      env_q       <= env_d;
      cap_q       <= cap_d;
      gate_seen_q <= gate_seen_d;
      start_q     <= start_d;
      stop_q      <= stop_d;
      cnt_q       <= cnt_d;
      mvalid_q    <= mvalid_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_ATTACK:  attack_q  <= cfg_data_i;
          CFG_DECAY:   decay_q   <= cfg_data_i;
          CFG_SUSTAIN: sustain_q <= cfg_data_i[LevelW-1:0];
          CFG_RELEASE: release_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    gate_q     <= gate_d;
    time_q     <= time_d;
    samp_q     <= samp_d;
    opa_q      <= opa_d;
    opb_q      <= opb_d;
    den_q      <= den_d;
    sub_q      <= sub_d;
    rem_q      <= rem_d;
    nlo_q      <= nlo_d;
    quot_q     <= quot_d;
    prod_q     <= prod_d;
    res_samp_q <= res_samp_d;
    res_lvl_q  <= res_lvl_d;
    out_samp_q <= out_samp_d;
    out_lvl_q  <= out_lvl_d;
  end

  // The envelope never exceeds full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni) env_q <= LevelOne)
    else $error("envelope level above full scale");

  // The divider never runs past its last quotient bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q <= DivLast))
    else $error("divider step count out of range");

  // An invalid sample leaves the envelope state alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && s_axis_tuser) |=> ($stable(phase_q) && $stable(env_q) && $stable(gate_seen_q)))
    else $error("invalid sample changed envelope state");

  // The reported level is the envelope level at the time the result is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && out_free) |-> (res_lvl_q == env_q))
    else $error("reported level differs from envelope");

  // A new item is taken only when the sequencer is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_PREP || state_q == ST_FIN))
    else $error("item accepted outside idle");

endmodule
